// File: src/lfu_pkg.sv
package lfu_pkg;

  // Default sizes
  localparam int RESIDENT_SLOTS_DEF = 4;
  localparam int BACKING_SLOTS_DEF  = 16;
  localparam int COUNT_BITS_DEF     = 16;

  // Field widths
  localparam int OP_W     = 1;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;

  // Request codes
  localparam logic [OP_W-1:0] OP_REF = 1'b0;
  localparam logic [OP_W-1:0] OP_ADD = 1'b1;

  // Result codes
  localparam logic [STATUS_W-1:0] ST_REF_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REF_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ADD_RESIDENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FROM_BACKING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NEW_LOADED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NEW_FULL     = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic rscan;
    logic bscan;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rscan_done;
    logic bscan_done;
    logic add_miss;
    logic out_free;
  } stat_t;

endpackage

// File: src/lfu_req_if.sv
interface lfu_req_if;
  logic                      valid;
  logic                      ready;
  logic [lfu_pkg::OP_W-1:0]  op;
  logic [lfu_pkg::ID_W-1:0]  page_id;

  modport source (output valid, op, page_id, input ready);
  modport sink   (input valid, op, page_id, output ready);
endinterface

// File: src/lfu_rsp_if.sv
interface lfu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lfu_pkg::STATUS_W-1:0]  status;
  logic [lfu_pkg::SLOT_W-1:0]    slot;
  logic                          evicted_valid;
  logic [lfu_pkg::ID_W-1:0]      evicted_id;

  modport source (output valid, status, slot, evicted_valid, evicted_id, input ready);
  modport sink   (input valid, status, slot, evicted_valid, evicted_id, output ready);
endinterface

// File: src/lfu_ram.sv
module lfu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/lfu_dp.sv
module lfu_dp #(
  parameter int RESIDENT_SLOTS = lfu_pkg::RESIDENT_SLOTS_DEF,
  parameter int BACKING_SLOTS  = lfu_pkg::BACKING_SLOTS_DEF,
  parameter int COUNT_BITS     = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lfu_pkg::cmd_t                  cmd_i,
  output lfu_pkg::stat_t                 stat_o,
  input  logic [lfu_pkg::OP_W-1:0]       req_op_i,
  input  logic [lfu_pkg::ID_W-1:0]       req_page_id_i,
  input  logic                           rsp_ready_i,
  output logic                           rsp_valid_o,
  output logic [lfu_pkg::STATUS_W-1:0]   rsp_status_o,
  output logic [lfu_pkg::SLOT_W-1:0]     rsp_slot_o,
  output logic                           rsp_evicted_valid_o,
  output logic [lfu_pkg::ID_W-1:0]       rsp_evicted_id_o
);

  localparam int RAW   = (RESIDENT_SLOTS > 1) ? $clog2(RESIDENT_SLOTS) : 1;
  localparam int RCW   = $clog2(RESIDENT_SLOTS + 1);
  localparam int BAW   = (BACKING_SLOTS > 1) ? $clog2(BACKING_SLOTS) : 1;
  localparam int BCW   = $clog2(BACKING_SLOTS + 1);
  localparam int IdW   = lfu_pkg::ID_W;
  localparam int SlotW = lfu_pkg::SLOT_W;

  // Request word
  logic [lfu_pkg::OP_W-1:0] op_q;
  logic [IdW-1:0]           id_q;

  // Resident scan
  logic [RCW-1:0]        ridx_q, rfill_q;
  logic                  rpend_q;
  logic [RAW-1:0]        rpend_idx_q;
  logic                  hit_q;
  logic [RAW-1:0]        hit_slot_q, min_pos_q;
  logic [COUNT_BITS-1:0] hit_cnt_q, min_cnt_q;
  logic [IdW-1:0]        min_id_q;

  // Backing scan
  logic [BCW-1:0] bidx_q, bfill_q;
  logic           bpend_q, bhit_q;
  logic [BAW-1:0] bpend_idx_q, bhit_idx_q;

  // Result register
  logic                         rsp_valid_q;
  logic [lfu_pkg::STATUS_W-1:0] rsp_status_q;
  logic [SlotW-1:0]             rsp_slot_q;
  logic                         rsp_ev_valid_q;
  logic [IdW-1:0]               rsp_ev_id_q;

  // Memory ports
  logic [IdW-1:0]        rid_rdata, bid_rdata;
  logic [COUNT_BITS-1:0] rcnt_rdata;
  logic                  r_issue, b_issue, r_match, r_min, b_match;

  // Commit decisions
  logic                         full, bfull;
  logic [COUNT_BITS-1:0]        bumped;
  logic [lfu_pkg::STATUS_W-1:0] st_c;
  logic [RAW-1:0]               slot_c, rwaddr_c;
  logic                         ev_valid_c;
  logic [IdW-1:0]               ev_id_c;
  logic                         id_we_c, cnt_we_c, bwe_c, rfill_inc_c, bfill_inc_c;
  logic [COUNT_BITS-1:0]        cnt_wdata_c;
  logic [BAW-1:0]               bwaddr_c;

  assign r_issue = cmd_i.rscan && (ridx_q < rfill_q);
  assign b_issue = cmd_i.bscan && (bidx_q < bfill_q);
  assign r_match = rpend_q && !hit_q && (rid_rdata == id_q);
  assign r_min   = rpend_q && ((rpend_idx_q == '0) || (min_cnt_q >= rcnt_rdata));
  assign b_match = bpend_q && !bhit_q && (bid_rdata == id_q);

  assign full   = (rfill_q == RCW'(RESIDENT_SLOTS));
  assign bfull  = (bfill_q == BCW'(BACKING_SLOTS));
  assign bumped = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + COUNT_BITS'(1);

  // Decide result and table writes from the finished scans
  always_comb begin
    st_c        = lfu_pkg::ST_REF_MISS;
    slot_c      = '0;
    ev_valid_c  = 1'b0;
    ev_id_c     = '0;
    id_we_c     = 1'b0;
    cnt_we_c    = 1'b0;
    cnt_wdata_c = '0;
    rwaddr_c    = hit_slot_q;
    bwe_c       = 1'b0;
    bwaddr_c    = bhit_idx_q;
    rfill_inc_c = 1'b0;
    bfill_inc_c = 1'b0;
    if (hit_q) begin
      st_c        = (op_q == lfu_pkg::OP_ADD) ? lfu_pkg::ST_ADD_RESIDENT : lfu_pkg::ST_REF_HIT;
      slot_c      = hit_slot_q;
      cnt_we_c    = 1'b1;
      cnt_wdata_c = bumped;
    end else if (op_q == lfu_pkg::OP_ADD) begin
      st_c     = bhit_q ? lfu_pkg::ST_FROM_BACKING : lfu_pkg::ST_NEW_LOADED;
      id_we_c  = 1'b1;
      cnt_we_c = 1'b1;
      if (!full) begin
        rwaddr_c    = rfill_q[RAW-1:0];
        slot_c      = rfill_q[RAW-1:0];
        rfill_inc_c = 1'b1;
      end else begin
        // Evict the last slot with the lowest count
        rwaddr_c   = min_pos_q;
        slot_c     = min_pos_q;
        ev_valid_c = 1'b1;
        ev_id_c    = min_id_q;
        if (bhit_q) begin
          bwe_c = 1'b1;
        end else if (!bfull) begin
          bwe_c       = 1'b1;
          bwaddr_c    = bfill_q[BAW-1:0];
          bfill_inc_c = 1'b1;
        end else begin
          st_c = lfu_pkg::ST_NEW_FULL;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q      <= '0;
      rpend_q     <= 1'b0;
      hit_q       <= 1'b0;
      bidx_q      <= '0;
      bpend_q     <= 1'b0;
      bhit_q      <= 1'b0;
      rfill_q     <= '0;
      bfill_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ridx_q  <= '0;
        rpend_q <= 1'b0;
        hit_q   <= 1'b0;
        bidx_q  <= '0;
        bpend_q <= 1'b0;
        bhit_q  <= 1'b0;
      end else begin
        rpend_q <= r_issue;
        bpend_q <= b_issue;
        if (r_issue) begin
          ridx_q <= ridx_q + RCW'(1);
        end
        if (b_issue) begin
          bidx_q <= bidx_q + BCW'(1);
        end
        if (r_match) begin
          hit_q <= 1'b1;
        end
        if (b_match) begin
          bhit_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        rsp_valid_q <= 1'b1;
        if (rfill_inc_c) begin
          rfill_q <= rfill_q + RCW'(1);
        end
        if (bfill_inc_c) begin
          bfill_q <= bfill_q + BCW'(1);
        end
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= req_op_i;
      id_q <= req_page_id_i;
    end
    rpend_idx_q <= ridx_q[RAW-1:0];
    bpend_idx_q <= bidx_q[BAW-1:0];
    if (r_match) begin
      hit_slot_q <= rpend_idx_q;
      hit_cnt_q  <= rcnt_rdata;
    end
    if (r_min) begin
      min_cnt_q <= rcnt_rdata;
      min_pos_q <= rpend_idx_q;
      min_id_q  <= rid_rdata;
    end
    if (b_match) begin
      bhit_idx_q <= bpend_idx_q;
    end
    if (cmd_i.commit) begin
      rsp_status_q   <= st_c;
      rsp_slot_q     <= SlotW'(slot_c);
      rsp_ev_valid_q <= ev_valid_c;
      rsp_ev_id_q    <= ev_id_c;
    end
  end

  lfu_ram #(.WIDTH(IdW), .DEPTH(RESIDENT_SLOTS)) u_rid_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && id_we_c),
    .waddr_i (rwaddr_c),
    .wdata_i (id_q),
    .raddr_i (ridx_q[RAW-1:0]),
    .rdata_o (rid_rdata)
  );

  lfu_ram #(.WIDTH(COUNT_BITS), .DEPTH(RESIDENT_SLOTS)) u_rcnt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && cnt_we_c),
    .waddr_i (rwaddr_c),
    .wdata_i (cnt_wdata_c),
    .raddr_i (ridx_q[RAW-1:0]),
    .rdata_o (rcnt_rdata)
  );

  lfu_ram #(.WIDTH(IdW), .DEPTH(BACKING_SLOTS)) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && bwe_c),
    .waddr_i (bwaddr_c),
    .wdata_i (min_id_q),
    .raddr_i (bidx_q[BAW-1:0]),
    .rdata_o (bid_rdata)
  );

  assign stat_o.rscan_done = !(ridx_q < rfill_q) && !rpend_q;
  assign stat_o.bscan_done = !(bidx_q < bfill_q) && !bpend_q;
  assign stat_o.add_miss   = (op_q == lfu_pkg::OP_ADD) && !hit_q;
  assign stat_o.out_free   = !rsp_valid_q || rsp_ready_i;

  assign rsp_valid_o         = rsp_valid_q;
  assign rsp_status_o        = rsp_status_q;
  assign rsp_slot_o          = rsp_slot_q;
  assign rsp_evicted_valid_o = rsp_ev_valid_q;
  assign rsp_evicted_id_o    = rsp_ev_id_q;

endmodule

// File: src/lfu_ctrl.sv
module lfu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  lfu_pkg::stat_t stat_i,
  output lfu_pkg::cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    IDLE,
    RSCAN,
    BSCAN,
    COMMIT
  } state_e;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      IDLE: begin
        if (req_valid_i) state_d = RSCAN;
      end
      RSCAN: begin
        if (stat_i.rscan_done) state_d = stat_i.add_miss ? BSCAN : COMMIT;
      end
      BSCAN: begin
        if (stat_i.bscan_done) state_d = COMMIT;
      end
      COMMIT: begin
        if (stat_i.out_free) state_d = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decode commands from state
  assign req_ready_o  = (state_q == IDLE);
  assign cmd_o.load   = (state_q == IDLE) && req_valid_i;
  assign cmd_o.rscan  = (state_q == RSCAN);
  assign cmd_o.bscan  = (state_q == BSCAN);
  assign cmd_o.commit = (state_q == COMMIT) && stat_i.out_free;

endmodule

// File: src/lfu_page_replacement.sv
// Channel | Dir | Word                                  | Accepted when
// req_i   | in  | op, page_id                           | valid && ready
// rsp_o   | out | status, slot, evicted_valid, evicted_id | valid && ready
//
// One request at a time: take the word, walk the resident table, walk the
// backing list on an add that misses, then commit the result.
// The walk is paced by the single read port of each table memory.
// Reset empties both tables through their fill counts; no clearing pass.
// A held result stalls the commit; no new word is taken until it is done.
module lfu_page_replacement #(
  parameter int RESIDENT_SLOTS = lfu_pkg::RESIDENT_SLOTS_DEF,
  parameter int BACKING_SLOTS  = lfu_pkg::BACKING_SLOTS_DEF,
  parameter int COUNT_BITS     = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lfu_req_if.sink   req_i,
  lfu_rsp_if.source rsp_o
);

  lfu_pkg::cmd_t  cmd;
  lfu_pkg::stat_t stat;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lfu_dp #(
    .RESIDENT_SLOTS (RESIDENT_SLOTS),
    .BACKING_SLOTS  (BACKING_SLOTS),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .req_op_i            (req_i.op),
    .req_page_id_i       (req_i.page_id),
    .rsp_ready_i         (rsp_o.ready),
    .rsp_valid_o         (rsp_o.valid),
    .rsp_status_o        (rsp_o.status),
    .rsp_slot_o          (rsp_o.slot),
    .rsp_evicted_valid_o (rsp_o.evicted_valid),
    .rsp_evicted_id_o    (rsp_o.evicted_id)
  );

  // Never overwrite a result that is still held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> stat.out_free)
    else $error("commit over a held result");

  // A committed result shows on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> rsp_o.valid)
    else $error("commit without result");

  // Taking a word makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("second word taken while busy");

  // A reference miss carries no slot and no eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status == lfu_pkg::ST_REF_MISS)) |->
      ((rsp_o.slot == '0) && !rsp_o.evicted_valid && (rsp_o.evicted_id == '0)))
    else $error("reference miss with slot or eviction");

endmodule

// File: tb/tb_lfu_page_replacement.sv
`timescale 1ns / 1ps

module tb_lfu_page_replacement;

  localparam int OP_W         = lfu_pkg::OP_W;
  localparam int ID_W         = lfu_pkg::ID_W;
  localparam int STATUS_W     = lfu_pkg::STATUS_W;
  localparam int SLOT_W       = lfu_pkg::SLOT_W;
  localparam int RES_SLOTS    = lfu_pkg::RESIDENT_SLOTS_DEF;
  localparam int BAK_SLOTS    = lfu_pkg::BACKING_SLOTS_DEF;
  localparam int CNT_W        = lfu_pkg::COUNT_BITS_DEF;
  localparam int RANDOM_WORDS = 1280;
  localparam int POOL_SIZE    = 24;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 4 * (RES_SLOTS + BAK_SLOTS + 6);

  // Mirror of the page tables; predicts one result word per request word
  class page_table_tracker;
    typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic                ev_valid;
      logic [ID_W-1:0]     ev_id;
    } outcome_t;

    logic [ID_W-1:0]  res_ids    [RES_SLOTS];
    logic [CNT_W-1:0] res_counts [RES_SLOTS];
    logic [ID_W-1:0]  bak_ids    [BAK_SLOTS];
    int unsigned      res_fill;
    int unsigned      bak_fill;
    outcome_t         pending_outcomes [$];
    int unsigned      mismatches;

    function new();
      res_fill   = 0;
      bak_fill   = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Apply an accepted request word to the mirror and queue its outcome
    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id);
      outcome_t         o;
      int               hit;
      int               bhit;
      int               pos;
      logic [CNT_W-1:0] minc;
      o    = '0;
      hit  = -1;
      bhit = -1;
      for (int i = 0; i < res_fill; i++)
        if (hit < 0 && res_ids[i] == id) hit = i;

      if (hit >= 0) begin
        // saturate rather than wrap
        if (res_counts[hit] != {CNT_W{1'b1}}) res_counts[hit]++;
        o.status = (op == lfu_pkg::OP_REF) ? lfu_pkg::ST_REF_HIT : lfu_pkg::ST_ADD_RESIDENT;
        o.slot   = SLOT_W'(hit);
      end else if (op == lfu_pkg::OP_REF) begin
        o.status = lfu_pkg::ST_REF_MISS;
      end else begin
        for (int i = 0; i < bak_fill; i++)
          if (bhit < 0 && bak_ids[i] == id) bhit = i;
        o.status = (bhit >= 0) ? lfu_pkg::ST_FROM_BACKING : lfu_pkg::ST_NEW_LOADED;
        if (res_fill < RES_SLOTS) begin
          o.slot               = SLOT_W'(res_fill);
          res_ids[res_fill]    = id;
          res_counts[res_fill] = '0;
          res_fill++;
        end else begin
          // victim: last slot holding the minimum count
          pos  = 0;
          minc = res_counts[0];
          for (int i = 0; i < RES_SLOTS; i++)
            if (res_counts[i] <= minc) begin
              minc = res_counts[i];
              pos  = i;
            end
          o.ev_valid      = 1'b1;
          o.ev_id         = res_ids[pos];
          o.slot          = SLOT_W'(pos);
          res_ids[pos]    = id;
          res_counts[pos] = '0;
          if (bhit >= 0) begin
            bak_ids[bhit] = o.ev_id;
          end else if (bak_fill < BAK_SLOTS) begin
            bak_ids[bak_fill] = o.ev_id;
            bak_fill++;
          end else begin
            o.status = lfu_pkg::ST_NEW_FULL;
          end
        end
      end
      pending_outcomes = {pending_outcomes, o};
    endfunction

    // Compare an accepted result word with the oldest outcome
    task check_outcome(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot,
                       logic ev_valid, logic [ID_W-1:0] ev_id);
      outcome_t o;
      if (pending_outcomes.size() == 0) begin
        report($sformatf("unexpected result status %0d slot %0d", status, slot));
        return;
      end
      o = pending_outcomes.pop_front();
      if (status !== o.status)
        report($sformatf("status %0d, wanted %0d", status, o.status));
      if (slot !== o.slot)
        report($sformatf("slot %0d, wanted %0d", slot, o.slot));
      if (ev_valid !== o.ev_valid)
        report($sformatf("evicted_valid %0b, wanted %0b", ev_valid, o.ev_valid));
      if (ev_id !== o.ev_id)
        report($sformatf("evicted_id %h, wanted %h", ev_id, o.ev_id));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  lfu_req_if req_if ();
  lfu_rsp_if rsp_if ();

  lfu_page_replacement dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  page_table_tracker tracker;
  bit                calm_run;
  int                hold_left;
  int                idle_cycles;
  logic [ID_W-1:0]   pool [POOL_SIZE];

  always #4 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one; none in a calm stretch
  function automatic int pick_gap();
    int r;
    if (calm_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  // Offer one request word after a random gap and hold it until taken
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.op      <= op;
    req_if.page_id <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    tracker.note_request(op, id);
  endtask

  // Check result words and stall the result side at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        tracker.check_outcome(rsp_if.status, rsp_if.slot,
                              rsp_if.evicted_valid, rsp_if.evicted_id);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        hold_left = pick_gap();
        rsp_if.ready <= (hold_left == 0);
        if (hold_left > 0) hold_left--;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    int              r;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.op      = lfu_pkg::OP_REF;
    req_if.page_id = '0;
    rsp_if.ready   = 1'b0;
    calm_run       = 1'b0;
    hold_left      = 0;
    idle_cycles    = 0;
    tracker        = new();
    pool[0]        = '0;
    pool[1]        = '1;
    for (int i = 2; i < POOL_SIZE; i++) pool[i] = ID_W'($urandom);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, fill, hits, first evictions, extreme ids
    send_request(lfu_pkg::OP_REF, 16'h0000);
    send_request(lfu_pkg::OP_ADD, 16'h0000);
    send_request(lfu_pkg::OP_ADD, 16'h0000);
    send_request(lfu_pkg::OP_REF, 16'h0000);
    send_request(lfu_pkg::OP_ADD, 16'hFFFF);
    send_request(lfu_pkg::OP_REF, 16'hFFFF);
    send_request(lfu_pkg::OP_ADD, 16'h0001);
    send_request(lfu_pkg::OP_ADD, 16'h0002);
    send_request(lfu_pkg::OP_REF, 16'h0007);
    send_request(lfu_pkg::OP_ADD, 16'h0003);
    send_request(lfu_pkg::OP_ADD, 16'h0002);
    send_request(lfu_pkg::OP_ADD, 16'h0005);
    send_request(lfu_pkg::OP_REF, 16'h0001);
    send_request(lfu_pkg::OP_REF, 16'h0001);
    send_request(lfu_pkg::OP_ADD, 16'h8000);
    send_request(lfu_pkg::OP_ADD, 16'h7FFF);
    send_request(lfu_pkg::OP_REF, 16'hFFFF);
    send_request(lfu_pkg::OP_ADD, 16'h0003);
    send_request(lfu_pkg::OP_ADD, 16'h0001);
    send_request(lfu_pkg::OP_ADD, 16'hFFFF);

    // Random: a small page pool keeps both tables busy, plus stray ids
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm_run = (n >= 500 && n < 650);
      r  = $urandom_range(0, 99);
      op = (r < 60) ? lfu_pkg::OP_ADD : lfu_pkg::OP_REF;
      r  = $urandom_range(0, 99);
      if (op == lfu_pkg::OP_REF && r < 25)
        id = tracker.res_ids[$urandom_range(0, RES_SLOTS - 1)];
      else if (r < 88)
        id = pool[$urandom_range(0, POOL_SIZE - 1)];
      else
        id = ID_W'($urandom);
      send_request(op, id);
    end
    calm_run = 1'b0;

    // Drain and let any stray result show up
    req_if.valid <= 1'b0;
    while (tracker.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
